// ----- design/hsv2rgb_pkg.sv -----
// Shared types, constants and helper functions for the HSV to RGB converter.
package hsv2rgb_pkg;

   // One hue sector spans 60 degrees, which is 3840 hue units (6 fraction bits).
   localparam int unsigned SECTOR_UNITS = 3840;
   // 1.0 in the Q1.8 saturation and value format.
   localparam int unsigned ONE_Q8       = 256;
   // SECTOR_UNITS * ONE_Q8, the full scale of the q and t numerators.
   localparam int unsigned FULL_SCALE   = 983040;

   typedef struct packed {
      logic [14:0] hue;
      logic [8:0]  saturation;
      logic [8:0]  brightness;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_out_type;

   // Hue sectors, in hue order starting at red.
   typedef enum logic [2:0] {
      SEC_RED_YELLOW    = 3'd0,
      SEC_YELLOW_GREEN  = 3'd1,
      SEC_GREEN_CYAN    = 3'd2,
      SEC_CYAN_BLUE     = 3'd3,
      SEC_BLUE_MAGENTA  = 3'd4,
      SEC_MAGENTA_RED   = 3'd5
   } sector_type;

   // Load enables for the four datapath register stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   // floor(coarse / 15) for the upper seven hue bits. Since 3840 = 15 * 256,
   // this equals floor(hue / 3840). Done as eight independent compares.
   function automatic logic [3:0] quot_of(input logic [6:0] coarse);
      logic [3:0] count;
      count = 4'd0;
      for (int k = 1; k <= 8; k++) begin
         if (coarse >= 7'(15 * k)) begin
            count = count + 4'd1;
         end
      end
      return count;
   endfunction

endpackage

// ----- design/hsv2rgb_core.sv -----
// Four-stage arithmetic datapath of the HSV to RGB converter.
module hsv2rgb_core (
   input  logic                       clock,
   input  hsv2rgb_pkg::stage_en_type  stage_en,
   input  hsv2rgb_pkg::pixel_in_type  req_word,
   output hsv2rgb_pkg::pixel_out_type rsp_word
);

   // Stage 1: sector, remainder within the sector, clamped inputs.
   logic [3:0]              quot;
   logic [6:0]              quot_x15;
   logic [14:0]             rem_full;
   logic [11:0]             rem_in, rem_ff;
   logic [8:0]              sat_in, sat_ff;
   logic [8:0]              bri_in, bri1_ff;
   hsv2rgb_pkg::sector_type sector_in, sector1_ff;

   always_comb begin
      quot      = hsv2rgb_pkg::quot_of(req_word.hue[14:8]);
      quot_x15  = 7'({3'b000, quot} * 7'd15);
      rem_full  = req_word.hue - {quot_x15, 8'h00};
      rem_in    = rem_full[11:0];
      sector_in = (quot >= 4'd6) ? hsv2rgb_pkg::sector_type'(3'(quot - 4'd6))
                                 : hsv2rgb_pkg::sector_type'(quot[2:0]);
      sat_in    = (req_word.saturation > 9'(hsv2rgb_pkg::ONE_Q8))
                ? 9'(hsv2rgb_pkg::ONE_Q8) : req_word.saturation;
      bri_in    = (req_word.brightness > 9'(hsv2rgb_pkg::ONE_Q8))
                ? 9'(hsv2rgb_pkg::ONE_Q8) : req_word.brightness;
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         rem_ff     <= rem_in;
         sat_ff     <= sat_in;
         bri1_ff    <= bri_in;
         sector1_ff <= sector_in;
      end
   end

   // Stage 2: numerators of q, t and p (before scaling by value).
   logic [11:0]             rem_comp;
   logic [19:0]             rs_prod, trs_prod;
   logic [19:0]             qa_in, qa_ff, ta_in, ta_ff;
   logic [8:0]              pa_in, pa_ff;
   logic [8:0]              bri2_ff;
   hsv2rgb_pkg::sector_type sector2_ff;

   always_comb begin
      rem_comp = 12'(hsv2rgb_pkg::SECTOR_UNITS) - rem_ff;
      rs_prod  = 20'(21'(rem_ff) * 21'(sat_ff));
      trs_prod = 20'(21'(rem_comp) * 21'(sat_ff));
      qa_in    = 20'(hsv2rgb_pkg::FULL_SCALE) - rs_prod;
      ta_in    = 20'(hsv2rgb_pkg::FULL_SCALE) - trs_prod;
      pa_in    = 9'(hsv2rgb_pkg::ONE_Q8) - sat_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         qa_ff      <= qa_in;
         ta_ff      <= ta_in;
         pa_ff      <= pa_in;
         bri2_ff    <= bri1_ff;
         sector2_ff <= sector1_ff;
      end
   end

   // Stage 3: scale by value.
   logic [28:0]             qx_in, qx_ff, tx_in, tx_ff;
   logic [16:0]             px_in, px_ff;
   logic [8:0]              bri3_ff;
   hsv2rgb_pkg::sector_type sector3_ff;

   always_comb begin
      qx_in = 29'(bri2_ff) * 29'(qa_ff);
      tx_in = 29'(bri2_ff) * 29'(ta_ff);
      px_in = 17'(bri2_ff) * 17'(pa_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         qx_ff      <= qx_in;
         tx_ff      <= tx_in;
         px_ff      <= px_in;
         bri3_ff    <= bri2_ff;
         sector3_ff <= sector2_ff;
      end
   end

   // Stage 4: times 255 and truncate. For q and t, 255 / (15 * 2^24) reduces
   // to 17 / 2^24, so the scaling is a shift-add and a bit select.
   logic [31:0]                q17, t17;
   logic [24:0]                p255;
   logic [16:0]                v255;
   logic [7:0]                 cq, ct, cp, cv;
   hsv2rgb_pkg::pixel_out_type word_in, word_ff;

   always_comb begin
      q17  = 32'({qx_ff, 4'h0}) + 32'(qx_ff);
      t17  = 32'({tx_ff, 4'h0}) + 32'(tx_ff);
      p255 = 25'({px_ff, 8'h00}) - 25'(px_ff);
      v255 = {bri3_ff, 8'h00} - 17'(bri3_ff);
      cq   = q17[31:24];
      ct   = t17[31:24];
      cp   = p255[23:16];
      cv   = v255[15:8];
      case (sector3_ff)
         hsv2rgb_pkg::SEC_RED_YELLOW:   word_in = '{red: cv, green: ct, blue: cp};
         hsv2rgb_pkg::SEC_YELLOW_GREEN: word_in = '{red: cq, green: cv, blue: cp};
         hsv2rgb_pkg::SEC_GREEN_CYAN:   word_in = '{red: cp, green: cv, blue: ct};
         hsv2rgb_pkg::SEC_CYAN_BLUE:    word_in = '{red: cp, green: cq, blue: cv};
         hsv2rgb_pkg::SEC_BLUE_MAGENTA: word_in = '{red: ct, green: cp, blue: cv};
         default:                       word_in = '{red: cv, green: cp, blue: cq};
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         word_ff <= word_in;
      end
   end

   assign rsp_word = word_ff;

endmodule

// ----- design/hsv_to_rgb_converter.sv -----
// Top level of the HSV to RGB converter: handshakes, stage valids, datapath.
// The converter takes one pixel word per clock unless stalled, as hue
// (degrees with six fraction bits), saturation and value (both Q1.8, where
// 256 means 1.0) and returns one word of 8-bit red, green and blue for each
// pixel, in order. Saturation and value above 1.0 are clamped to 1.0,
// and hue above 360 degrees wraps through the sector count, so 360 degrees
// reads as 0. Throughput is one pixel per clock cycle while rsp_stall is
// low. The accepting edge loads the first of four register stages, and
// the word appears on rsp_valid once it reaches the last of them. The
// four stages are sector split, numerator products, scaling by value, and
// the final times-255 scaling with channel selection.
// Each stage carries its own valid bit and loads whenever it is empty or
// its successor moves, so bubbles close up under a stall and req_stall
// rises only when all four stages hold a word and the output is stalled.
module hsv_to_rgb_converter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  hsv2rgb_pkg::pixel_in_type  req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output hsv2rgb_pkg::pixel_out_type rsp_word
);

   // Valid bits, one per datapath stage.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;

   // A stage may load when it is empty or when its word moves on this cycle.
   logic ready1, ready2, ready3, ready4;
   hsv2rgb_pkg::stage_en_type stage_en;

   always_comb begin
      ready4 = !v4_ff || !rsp_stall;
      ready3 = !v3_ff || ready4;
      ready2 = !v2_ff || ready3;
      ready1 = !v1_ff || ready2;

      stage_en.s1 = ready1;
      stage_en.s2 = ready2;
      stage_en.s3 = ready3;
      stage_en.s4 = ready4;

      v1_in = ready1 ? req_valid : v1_ff;
      v2_in = ready2 ? v1_ff     : v2_ff;
      v3_in = ready3 ? v2_ff     : v3_ff;
      v4_in = ready4 ? v3_ff     : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req_stall = !ready1;
   assign rsp_valid = v4_ff;

   hsv2rgb_core u_core (
      .clock    (clock),
      .stage_en (stage_en),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

   // The input is held off only when every stage is full.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("input stalled while the pipeline has a free stage");

   // An accepted word lands in the first stage.
   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted word did not enter the first stage");

   // A word that cannot advance stays in its stage.
   a_blocked_word_kept: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !ready4) |=> (v3_ff && v4_ff))
      else $error("blocked word was lost from the third stage");

endmodule

// ----- verif/tb_hsv_to_rgb_converter.sv -----
// Self-checking testbench for the HSV to RGB converter with random flow control.
module tb_hsv_to_rgb_converter;

   timeunit 1ns;
   timeprecision 1ps;

   // All inputs of the converter start at known values. The clock starts low.
   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   hsv2rgb_pkg::pixel_in_type  req_word  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   hsv2rgb_pkg::pixel_out_type rsp_word;

   // Colors that the converter still owes us, oldest first.
   hsv2rgb_pkg::pixel_out_type pending_rgb[$];
   int unsigned   mismatch_count = 0;
   // Chance, in percent, that a side idles in a given cycle. Both the pixel
   // sender and the result receiver follow it, so setting it to zero gives a
   // stretch where words move back to back.
   int unsigned   idle_pct = 12;

   hsv_to_rgb_converter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // The clock has a 20 ns period: 10 ns high, then 10 ns low.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // One channel value: floor(255 * num / den), held to the 8-bit range.
   function automatic logic [7:0] scale255(input longint unsigned num,
                                           input longint unsigned den);
      longint unsigned x;
      x = (num * 255) / den;
      if (x > 255) begin
         x = 255;
      end
      return x[7:0];
   endfunction

   // Exact prediction of one converted pixel. Saturation and value are
   // clamped to 1.0 first; the sector repeats every six, so 360 degrees and
   // beyond fold back onto the red end with the same fraction.
   function automatic hsv2rgb_pkg::pixel_out_type predict_rgb(
      input hsv2rgb_pkg::pixel_in_type px);
      longint unsigned            h, s, v, r;
      longint unsigned            full;
      logic [7:0]                 cv, cp, cq, ct;
      hsv2rgb_pkg::sector_type    sec;
      hsv2rgb_pkg::pixel_out_type rgb;
      h = px.hue;
      s = (px.saturation > hsv2rgb_pkg::ONE_Q8) ? hsv2rgb_pkg::ONE_Q8 : px.saturation;
      v = (px.brightness > hsv2rgb_pkg::ONE_Q8) ? hsv2rgb_pkg::ONE_Q8 : px.brightness;
      full = hsv2rgb_pkg::FULL_SCALE;
      sec = hsv2rgb_pkg::sector_type'((h / hsv2rgb_pkg::SECTOR_UNITS) % 6);
      r = h % hsv2rgb_pkg::SECTOR_UNITS;
      cv = scale255(v, hsv2rgb_pkg::ONE_Q8);
      cp = scale255(v * (hsv2rgb_pkg::ONE_Q8 - s),
                    hsv2rgb_pkg::ONE_Q8 * hsv2rgb_pkg::ONE_Q8);
      cq = scale255(v * (full - r * s), full * hsv2rgb_pkg::ONE_Q8);
      ct = scale255(v * (full - (hsv2rgb_pkg::SECTOR_UNITS - r) * s),
                    full * hsv2rgb_pkg::ONE_Q8);
      case (sec)
         hsv2rgb_pkg::SEC_RED_YELLOW: begin
            rgb = '{red: cv, green: ct, blue: cp};
         end
         hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
            rgb = '{red: cq, green: cv, blue: cp};
         end
         hsv2rgb_pkg::SEC_GREEN_CYAN: begin
            rgb = '{red: cp, green: cv, blue: ct};
         end
         hsv2rgb_pkg::SEC_CYAN_BLUE: begin
            rgb = '{red: cp, green: cq, blue: cv};
         end
         hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
            rgb = '{red: ct, green: cp, blue: cv};
         end
         default: begin
            rgb = '{red: cv, green: cp, blue: cq};
         end
      endcase
      return rgb;
   endfunction

   // Offers one pixel word and returns at the edge where it is accepted.
   // The task is always entered at a rising edge. Idle cycles come first,
   // then the word is held steady until the converter stops stalling. The
   // stall seen right after the edge is still the value that the edge
   // sampled, so the acceptance test matches what the converter saw.
   task automatic send_pixel(input hsv2rgb_pkg::pixel_in_type px);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= px;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_rgb.push_back(predict_rgb(px));
   endtask

   // The receiver stalls at random, except during reset.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // Every accepted result word is matched against the oldest prediction.
   always @(posedge clock) begin
      hsv2rgb_pkg::pixel_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rgb.size() == 0) begin
            $error("result word %h arrived with no pixel outstanding", rsp_word);
            mismatch_count++;
         end else begin
            want = pending_rgb.pop_front();
            if (rsp_word.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_word.red);
               mismatch_count++;
            end
            if (rsp_word.green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_word.green);
               mismatch_count++;
            end
            if (rsp_word.blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_word.blue);
               mismatch_count++;
            end
         end
      end
   end

   // Sector boundaries, the 360 degree wrap, the largest hue word, and the
   // extremes of saturation and value, including the clamped codes above 1.0.
   task automatic test_sector_edges();
      hsv2rgb_pkg::pixel_in_type px;
      for (int k = 0; k <= 6; k++) begin
         px = '{hue: 15'(k * hsv2rgb_pkg::SECTOR_UNITS), saturation: 9'd256,
                brightness: 9'd256};
         send_pixel(px);
      end
      for (int k = 1; k <= 6; k++) begin
         px = '{hue: 15'(k * hsv2rgb_pkg::SECTOR_UNITS - 1), saturation: 9'd200,
                brightness: 9'd256};
         send_pixel(px);
      end
      send_pixel('{hue: 15'd32767, saturation: 9'd256, brightness: 9'd256});
      send_pixel('{hue: 15'd1920,  saturation: 9'd0,   brightness: 9'd256});
      send_pixel('{hue: 15'd9000,  saturation: 9'd256, brightness: 9'd0});
      send_pixel('{hue: 15'd0,     saturation: 9'd0,   brightness: 9'd0});
      send_pixel('{hue: 15'd5000,  saturation: 9'd511, brightness: 9'd511});
      send_pixel('{hue: 15'd14000, saturation: 9'd257, brightness: 9'd128});
      send_pixel('{hue: 15'd20000, saturation: 9'd128, brightness: 9'd300});
      send_pixel('{hue: 15'd23040, saturation: 9'd511, brightness: 9'd1});
      send_pixel('{hue: 15'd1,     saturation: 9'd1,   brightness: 9'd255});
      send_pixel('{hue: 15'd26880, saturation: 9'd255, brightness: 9'd256});
   endtask

   // A random legal pixel. Saturation and value lean toward 1.0 now
   // and then, since the edges of the products are where truncation bites.
   function automatic hsv2rgb_pkg::pixel_in_type legal_pixel();
      hsv2rgb_pkg::pixel_in_type px;
      px.hue        = 15'($urandom_range(23040));
      px.saturation = ($urandom_range(9) == 0) ? 9'd256 : 9'($urandom_range(256));
      px.brightness = ($urandom_range(9) == 0) ? 9'd256 : 9'($urandom_range(256));
      return px;
   endfunction

   // Random legal pixels under random idling on both sides.
   task automatic test_random_legal(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         send_pixel(legal_pixel());
      end
   endtask

   // Back-to-back words with neither side idling, so the pipeline runs full.
   task automatic test_full_rate(input int unsigned count);
      idle_pct = 0;
      for (int unsigned n = 0; n < count; n++) begin
         send_pixel(legal_pixel());
      end
      idle_pct = 12;
   endtask

   // Any bit pattern at all: hues past 360 degrees, and saturation and value
   // above 1.0, which the converter must clamp.
   task automatic test_full_width(input int unsigned count);
      hsv2rgb_pkg::pixel_in_type px;
      for (int unsigned n = 0; n < count; n++) begin
         px.hue        = 15'($urandom);
         px.saturation = 9'($urandom);
         px.brightness = 9'($urandom);
         send_pixel(px);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sector_edges();
      test_random_legal(250);
      test_full_rate(120);
      test_full_width(120);
      test_random_legal(60);

      req_valid <= 1'b0;
      // Drain the pipeline, then keep clocking so that any stray extra word
      // would still be caught by the checker.
      while (pending_rgb.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- hsv_to_rgb_converter.f -----
design/hsv2rgb_pkg.sv
design/hsv2rgb_core.sv
design/hsv_to_rgb_converter.sv
verif/tb_hsv_to_rgb_converter.sv
